// ----- rtl/core/ccsc_pkg.sv -----
// Shared types and constants for the CRC codeword stream checker.
`timescale 1ns / 1ps

package ccsc_pkg;

   localparam int BYTE_W      = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_CNT_W   = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_GEN_POLY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEN_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DW_EIGHT = 2'd2;

   localparam logic [15:0] RST_GEN_POLY = 16'd11;
   localparam logic [4:0]  RST_GEN_LEN  = 5'd4;
   localparam logic        RST_DW_EIGHT = 1'b0;

   localparam logic RSP_KIND_DATA    = 1'b0;
   localparam logic RSP_KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           data_byte;
      logic [OUT_CNT_W-1:0] codeword_total;
      logic [OUT_CNT_W-1:0] error_total;
      logic                 last_result;
   } rsp_type;

   typedef struct packed {
      logic [15:0] generator_poly;
      logic [4:0]  generator_length;
      logic        dataword_eight;
   } cfg_type;

   typedef struct packed {
      logic       header;
      logic [7:0] data;
      logic       last;
   } q_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BITS,
      ST_REDIV,
      ST_COMPLETE,
      ST_SUMMARY
   } back_state_type;

endpackage

// ----- rtl/core/crc_codeword_stream_checker.sv -----
// Top level of the CRC codeword stream checker: registers, front end, queue and checker.
// The bit-serial divider takes one bit of each data byte per cycle unless a full
// result slot or a recheck holds it. After a register write the next codeword to
// complete is divided again from its stored bits.
// Synchronous reset restores the registers to their defaults and starts a new stream.
`timescale 1ns / 1ps

module crc_codeword_stream_checker #(
   parameter int MAX_GEN_LEN = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  ccsc_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ccsc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [ccsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccsc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ccsc_pkg::*;

   logic [15:0]  gen_poly_ff, gen_poly_in;
   logic [4:0]   gen_len_ff, gen_len_in;
   logic         dw_eight_ff, dw_eight_in;
   cfg_type      cfg;
   logic         q_full;
   logic         q_empty;
   logic         q_push;
   logic         q_pop;
   q_entry_type  q_entry;
   q_entry_type  q_head;

   always_comb begin
      gen_poly_in = gen_poly_ff;
      gen_len_in  = gen_len_ff;
      dw_eight_in = dw_eight_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GEN_POLY: gen_poly_in = csr_wdata;
            CSR_GEN_LEN:  gen_len_in  = csr_wdata[4:0];
            CSR_DW_EIGHT: dw_eight_in = csr_wdata[0];
            default: begin
               gen_poly_in = gen_poly_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_poly_ff <= RST_GEN_POLY;
         gen_len_ff  <= RST_GEN_LEN;
         dw_eight_ff <= RST_DW_EIGHT;
      end else begin
         gen_poly_ff <= gen_poly_in;
         gen_len_ff  <= gen_len_in;
         dw_eight_ff <= dw_eight_in;
      end
   end

   always_comb begin
      cfg.generator_poly   = gen_poly_ff;
      cfg.generator_length = gen_len_ff;
      cfg.dataword_eight   = dw_eight_ff;
   end

   ccsc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   ccsc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   ccsc_back #(
      .MAX_GEN_LEN (MAX_GEN_LEN),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .cfg_write (csr_we),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- rtl/core/ccsc_front.sv -----
// Front end: accepts input beats and tags each as stream header or data byte.
`timescale 1ns / 1ps

module ccsc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ccsc_pkg::req_type     req_data,
   input  logic                  q_full,
   output logic                  q_push,
   output ccsc_pkg::q_entry_type q_entry
);
   import ccsc_pkg::*;

   logic header_pending_ff;
   logic header_pending_in;
   logic accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   always_comb begin
      q_entry.header = header_pending_ff;
      q_entry.data   = req_data.in_byte;
      q_entry.last   = req_data.last_byte;
   end

   // After a last beat the next beat opens a new stream with its pad count.
   always_comb begin
      header_pending_in = header_pending_ff;
      if (accept) begin
         header_pending_in = req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_pending_ff <= 1'b1;
      end else begin
         header_pending_ff <= header_pending_in;
      end
   end

endmodule

// ----- rtl/core/ccsc_queue.sv -----
// Short beat queue between the front end and the serial checker.
`timescale 1ns / 1ps

module ccsc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ccsc_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output ccsc_pkg::q_entry_type head,
   output logic                  empty,
   output logic                  full
);
   import ccsc_pkg::*;

   q_entry_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]        wr_ptr_ff;
   logic [QPTR_W-1:0]        wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff;
   logic [QPTR_W-1:0]        rd_ptr_in;
   logic [QCNT_W-1:0]        count_ff;
   logic [QCNT_W-1:0]        count_in;
   logic                     do_push;
   logic                     do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/ccsc_back.sv -----
// Back end: bit-serial CRC division, data byte packing, counters and result register.
`timescale 1ns / 1ps

module ccsc_back #(
   parameter int MAX_GEN_LEN = 16,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ccsc_pkg::q_entry_type head,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  ccsc_pkg::cfg_type     cfg,
   input  logic                  cfg_write,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ccsc_pkg::rsp_type     rsp_data
);
   import ccsc_pkg::*;

   localparam int W    = MAX_GEN_LEN;
   localparam int LMAX = MAX_GEN_LEN + 7;
   localparam int GLW  = $clog2(MAX_GEN_LEN + 1);
   localparam int DEGW = $clog2(MAX_GEN_LEN);
   localparam int LW   = $clog2(LMAX + 1);
   localparam int PW   = $clog2(LMAX);
   localparam int CW   = COUNT_WIDTH;

   back_state_type   state_ff, state_in;
   logic [2:0]       bit_idx_ff, bit_idx_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic [7:0]       skip_ff, skip_in;
   logic [LMAX-1:0]  shift_ff, shift_in;
   logic [LW-1:0]    count_ff, count_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [PW-1:0]    pos_ff, pos_in;
   logic [3:0]       oa_ff, oa_in;
   logic [3:0]       obc_ff, obc_in;
   logic [CW-1:0]    cw_cnt_ff, cw_cnt_in;
   logic [CW-1:0]    err_cnt_ff, err_cnt_in;
   logic             dirty_ff, dirty_in;
   logic             out_valid_ff, out_valid_in;
   rsp_type          out_data_ff, out_data_in;

   logic [GLW-1:0]   glen;
   logic [3:0]       dw;
   logic [LW-1:0]    len;
   logic [W-1:0]     gmask;
   logic [W-1:0]     g;
   logic             gnz;
   logic [DEGW-1:0]  deg;
   logic [LMAX-1:0]  tmask;

   logic             cur_bit;
   logic [LMAX-1:0]  shift_nx;
   logic [LW-1:0]    count_nx;
   logic [W-1:0]     rem_nx;
   logic [LMAX-1:0]  cmp_shift;
   logic [W-1:0]     cmp_rem;
   logic [LW-1:0]    sel_amt;
   logic [7:0]       d8;
   logic [7:0]       dbits;
   logic             cw_err;
   logic [CW-1:0]    cw_cnt_sat;
   logic [CW-1:0]    err_cnt_new;
   logic [11:0]      asm12;
   logic [3:0]       obc_sum;
   logic             emit;
   logic [3:0]       sh_amt;
   logic [7:0]       emit_byte;
   logic [3:0]       oa_keep;
   logic             slot_free;
   logic             do_complete;
   logic             advance;
   logic             end_byte;
   logic             fetch;

   function automatic logic [W-1:0] crc_step(
      input logic [W-1:0]    rem,
      input logic            din,
      input logic [W-1:0]    gp,
      input logic            gp_nz,
      input logic [DEGW-1:0] gp_deg
   );
      logic [W:0]   sh;
      logic [W-1:0] lo;
      sh = {rem, din};
      lo = sh[W-1:0];
      if (gp_nz && lo[gp_deg]) begin
         sh = sh ^ {1'b0, gp};
      end
      return sh[W-1:0];
   endfunction

   always_comb begin
      if (cfg.generator_length < 5'd2) begin
         glen = GLW'(2);
      end else if (int'(cfg.generator_length) > MAX_GEN_LEN) begin
         glen = GLW'(MAX_GEN_LEN);
      end else begin
         glen = GLW'(cfg.generator_length);
      end
      dw  = cfg.dataword_eight ? 4'd8 : 4'd4;
      len = LW'(dw) + LW'(glen) - LW'(1);
      for (int i = 0; i < W; i++) begin
         gmask[i] = (i < int'(glen));
      end
      g   = W'(cfg.generator_poly) & gmask;
      gnz = |g;
      deg = '0;
      for (int i = 0; i < W; i++) begin
         if (g[i]) begin
            deg = DEGW'(i);
         end
      end
      for (int i = 0; i < LMAX; i++) begin
         tmask[i] = (i < int'(glen) - 1);
      end
   end

   // Completion datapath, shared by the direct path and the recheck path.
   always_comb begin
      cur_bit   = byte_ff[3'd7 - bit_idx_ff];
      shift_nx  = {shift_ff[LMAX-2:0], cur_bit};
      count_nx  = count_ff + LW'(1);
      rem_nx    = crc_step(rem_ff, cur_bit, g, gnz, deg);
      cmp_shift = (state_ff == ST_COMPLETE) ? shift_ff : shift_nx;
      cmp_rem   = (state_ff == ST_COMPLETE) ? rem_ff : rem_nx;
      sel_amt   = len - LW'(dw);
      d8        = 8'(cmp_shift >> sel_amt);
      dbits     = cfg.dataword_eight ? d8 : {4'b0, d8[3:0]};
      cw_err    = gnz ? (|cmp_rem) : (|(cmp_shift & tmask));
      cw_cnt_sat  = (cw_cnt_ff == '1) ? cw_cnt_ff : cw_cnt_ff + CW'(1);
      err_cnt_new = (cw_err && (err_cnt_ff != '1)) ? err_cnt_ff + CW'(1) : err_cnt_ff;
      asm12     = ({8'b0, oa_ff} << dw) | {4'b0, dbits};
      obc_sum   = obc_ff + dw;
      emit      = (obc_sum >= 4'd8);
      sh_amt    = obc_sum - 4'd8;
      emit_byte = 8'(asm12 >> sh_amt);
      oa_keep   = emit ? 4'(asm12 & ((12'd1 << sh_amt) - 12'd1)) : asm12[3:0];
      slot_free = !out_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      bit_idx_in   = bit_idx_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      skip_in      = skip_ff;
      shift_in     = shift_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      pos_in       = pos_ff;
      oa_in        = oa_ff;
      obc_in       = obc_ff;
      cw_cnt_in    = cw_cnt_ff;
      err_cnt_in   = err_cnt_ff;
      dirty_in     = dirty_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      do_complete  = 1'b0;
      advance      = 1'b0;
      end_byte     = 1'b0;
      fetch        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            fetch = 1'b1;
         end
         ST_BITS: begin
            if (skip_ff != 8'd0) begin
               skip_in = skip_ff - 8'd1;
               advance = 1'b1;
            end else if (count_nx >= len) begin
               if (dirty_ff) begin
                  // Configuration written since the last completed codeword: divide it again.
                  shift_in = shift_nx;
                  rem_in   = '0;
                  pos_in   = PW'(len - LW'(1));
                  state_in = ST_REDIV;
               end else if (!emit || slot_free) begin
                  do_complete = 1'b1;
                  advance     = 1'b1;
               end
            end else begin
               shift_in = shift_nx;
               count_in = count_nx;
               rem_in   = rem_nx;
               advance  = 1'b1;
            end
         end
         ST_REDIV: begin
            rem_in = crc_step(rem_ff, shift_ff[pos_ff], g, gnz, deg);
            pos_in = pos_ff - PW'(1);
            if (pos_ff == '0) begin
               state_in = ST_COMPLETE;
            end
         end
         ST_COMPLETE: begin
            if (!emit || slot_free) begin
               do_complete = 1'b1;
               advance     = 1'b1;
               state_in    = ST_BITS;
            end
         end
         ST_SUMMARY: begin
            if (slot_free) begin
               out_valid_in               = 1'b1;
               out_data_in.kind           = RSP_KIND_SUMMARY;
               out_data_in.data_byte      = 8'd0;
               out_data_in.codeword_total = OUT_CNT_W'(cw_cnt_ff);
               out_data_in.error_total    = OUT_CNT_W'(err_cnt_ff);
               out_data_in.last_result    = 1'b1;
               skip_in    = 8'd0;
               shift_in   = '0;
               count_in   = '0;
               rem_in     = '0;
               oa_in      = 4'd0;
               obc_in     = 4'd0;
               cw_cnt_in  = '0;
               err_cnt_in = '0;
               dirty_in   = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_complete) begin
         shift_in   = '0;
         count_in   = '0;
         rem_in     = '0;
         dirty_in   = 1'b0;
         cw_cnt_in  = cw_cnt_sat;
         err_cnt_in = err_cnt_new;
         oa_in      = oa_keep;
         obc_in     = emit ? sh_amt : obc_sum;
         if (emit) begin
            // At most one data byte per input beat, so it is the final one
            // unless a summary follows.
            out_valid_in               = 1'b1;
            out_data_in.kind           = RSP_KIND_DATA;
            out_data_in.data_byte      = emit_byte;
            out_data_in.codeword_total = OUT_CNT_W'(cw_cnt_sat);
            out_data_in.error_total    = OUT_CNT_W'(err_cnt_new);
            out_data_in.last_result    = !last_ff;
         end
      end

      if (advance) begin
         if (bit_idx_ff == 3'd7) begin
            end_byte = 1'b1;
         end else begin
            bit_idx_in = bit_idx_ff + 3'd1;
         end
      end

      if (end_byte) begin
         if (last_ff) begin
            state_in = ST_SUMMARY;
         end else begin
            fetch = 1'b1;
         end
      end

      if (fetch) begin
         state_in = ST_IDLE;
         if (!q_empty) begin
            q_pop = 1'b1;
            if (head.header) begin
               skip_in = head.data;
               if (head.last) begin
                  state_in = ST_SUMMARY;
               end
            end else begin
               byte_in    = head.data;
               last_in    = head.last;
               bit_idx_in = 3'd0;
               state_in   = ST_BITS;
            end
         end
      end

      if (cfg_write) begin
         dirty_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_idx_ff   <= 3'd0;
         last_ff      <= 1'b0;
         skip_ff      <= 8'd0;
         shift_ff     <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         pos_ff       <= '0;
         oa_ff        <= 4'd0;
         obc_ff       <= 4'd0;
         cw_cnt_ff    <= '0;
         err_cnt_ff   <= '0;
         dirty_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_idx_ff   <= bit_idx_in;
         last_ff      <= last_in;
         skip_ff      <= skip_in;
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         pos_ff       <= pos_in;
         oa_ff        <= oa_in;
         obc_ff       <= obc_in;
         cw_cnt_ff    <= cw_cnt_in;
         err_cnt_ff   <= err_cnt_in;
         dirty_ff     <= dirty_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ----- tb/ccsc_result_checker.sv -----
// Checker for the CRC codeword stream checker: predicts every result beat and compares it.
`timescale 1ns / 1ps

module ccsc_result_checker #(
   parameter int MAX_GEN_LEN = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  ccsc_pkg::req_type                 req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  ccsc_pkg::rsp_type                 rsp_data,
   input  logic                              csr_we,
   input  logic [ccsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ccsc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output int unsigned                       mismatch_count,
   output int unsigned                       results_outstanding
);

   import ccsc_pkg::*;

   logic [15:0] poly_reg;
   logic [4:0]  glen_reg;
   logic        d8_reg;

   logic        hdr_pending;
   logic [7:0]  skip_left;
   logic [31:0] cw_shift;
   int          cw_count;
   logic [11:0] out_asm;
   int          out_count;
   logic [31:0] cw_total;
   logic [31:0] err_total;

   rsp_type     predicted_rsp_q[$];

   initial begin
      mismatch_count      = 0;
      results_outstanding = 0;
   end

   function automatic bit has_remainder(input logic [31:0] cw, input int len, input int glen,
                                        input logic [15:0] poly);
      logic [31:0] g;
      logic [31:0] r;
      int          deg;
      int          b;
      int          p;
      g = {16'd0, poly} & ((32'd1 << glen) - 1);
      if (g == 0)
         return (cw & ((32'd1 << (glen - 1)) - 1)) != 0;
      deg = 0;
      for (b = 0; b < glen; b++)
         if (g[b]) deg = b;
      r = cw;
      for (p = len - 1; p >= deg; p--)
         if (r[p]) r ^= g << (p - deg);
      return r != 0;
   endfunction

   task automatic clear_stream();
      hdr_pending = 1'b1;
      skip_left   = '0;
      cw_shift    = '0;
      cw_count    = 0;
      out_asm     = '0;
      out_count   = 0;
      cw_total    = '0;
      err_total   = '0;
   endtask

   task automatic push_result(input logic kind, input logic [7:0] data);
      rsp_type r;
      r.kind           = kind;
      r.data_byte      = data;
      r.codeword_total = cw_total;
      r.error_total    = err_total;
      r.last_result    = 1'b0;
      predicted_rsp_q.push_back(r);
   endtask

   task automatic predict_beat(input req_type beat);
      rsp_type     r;
      int          n_before;
      int          glen;
      int          dw;
      int          len;
      int          sh;
      int          i;
      logic [31:0] cw;
      logic [7:0]  dbits;
      n_before = predicted_rsp_q.size();
      if (hdr_pending) begin
         hdr_pending = 1'b0;
         skip_left   = beat.in_byte;
      end else begin
         glen = (glen_reg < 2) ? 2 : (glen_reg > MAX_GEN_LEN) ? MAX_GEN_LEN : glen_reg;
         dw   = d8_reg ? 8 : 4;
         len  = dw + glen - 1;
         for (i = 0; i < 8; i++) begin
            if (skip_left > 0) begin
               skip_left--;
               continue;
            end
            cw_shift = {cw_shift[30:0], beat.in_byte[7 - i]};
            cw_count++;
            if (cw_count >= len) begin
               cw    = cw_shift & ((32'd1 << len) - 1);
               dbits = 8'((cw >> (len - dw)) & ((32'd1 << dw) - 1));
               if (cw_total != '1) cw_total++;
               if (has_remainder(cw, len, glen, poly_reg) && err_total != '1) err_total++;
               cw_shift  = '0;
               cw_count  = 0;
               out_asm   = 12'(({20'd0, out_asm} << dw) | {24'd0, dbits});
               out_count = out_count + dw;
               if (out_count >= 8) begin
                  sh = out_count - 8;
                  push_result(RSP_KIND_DATA, 8'(out_asm >> sh));
                  out_count = sh;
                  out_asm   = out_asm & 12'((32'd1 << sh) - 1);
               end
            end
         end
      end
      if (beat.last_byte) begin
         push_result(RSP_KIND_SUMMARY, 8'd0);
         clear_stream();
      end
      if (predicted_rsp_q.size() > n_before) begin
         r = predicted_rsp_q.pop_back();
         r.last_result = 1'b1;
         predicted_rsp_q.push_back(r);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         poly_reg = RST_GEN_POLY;
         glen_reg = RST_GEN_LEN;
         d8_reg   = RST_DW_EIGHT;
         clear_stream();
         predicted_rsp_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_GEN_POLY: poly_reg = csr_wdata;
               CSR_GEN_LEN:  glen_reg = csr_wdata[4:0];
               CSR_DW_EIGHT: d8_reg   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp_q.size() == 0) begin
               $error("Result beat with nothing expected: kind %0h data_byte %0h",
                      rsp_data.kind, rsp_data.data_byte);
               mismatch_count++;
            end else begin
               want = predicted_rsp_q.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("data_byte", want.data_byte, rsp_data.data_byte);
               check_field("codeword_total", want.codeword_total, rsp_data.codeword_total);
               check_field("error_total", want.error_total, rsp_data.error_total);
               check_field("last_result", want.last_result, rsp_data.last_result);
            end
         end
      end
      results_outstanding = predicted_rsp_q.size();
   end

endmodule

// ----- tb/crc_codeword_stream_checker_tb.sv -----
// Testbench top for the CRC codeword stream checker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module crc_codeword_stream_checker_tb;

   import ccsc_pkg::*;

   localparam int SETTLE_CYCLES = 80;
   localparam int LONG_HOLD     = 300;
   localparam int TARGET_BEATS  = 480;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned results_outstanding;
   int          beats_sent;
   bit          send_idle;
   bit          recv_idle;
   bit          long_hold_req;
   logic [15:0] cfg_poly;
   logic [4:0]  cfg_len;
   logic        cfg_d8;

   always #4 clock = ~clock;

   crc_codeword_stream_checker #(
      .MAX_GEN_LEN(16),
      .COUNT_WIDTH(32)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   ccsc_result_checker #(
      .MAX_GEN_LEN(16)
   ) chk (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .results_outstanding(results_outstanding)
   );

   task automatic send_beat(input logic [7:0] b, input logic l);
      int gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      repeat (gap) @(negedge clock);
      req_data.in_byte   = b;
      req_data.last_byte = l;
      req_valid          = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      beats_sent++;
   endtask

   task automatic write_cfg(input logic [15:0] poly, input logic [4:0] glen, input logic d8);
      cfg_poly  = poly;
      cfg_len   = glen;
      cfg_d8    = d8;
      csr_we    = 1'b1;
      csr_index = CSR_GEN_POLY;
      csr_wdata = poly;
      @(negedge clock);
      csr_index = CSR_GEN_LEN;
      csr_wdata = {11'd0, glen};
      @(negedge clock);
      csr_index = CSR_DW_EIGHT;
      csr_wdata = {15'd0, d8};
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_random_cfg();
      logic [4:0] glen;
      glen = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                         : 5'($urandom_range(2, 16));
      write_cfg(16'($urandom_range(0, 65535)), glen, 1'($urandom_range(0, 1)));
   endtask

   task automatic wait_idle();
      while (results_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Valid codewords are built as multiples of the generator (with zero check bits when
   // the generator is zero), a quarter of them then have one bit flipped.
   task automatic send_stream(input bit with_header, input int pad, input int n_cw,
                              input int tail, input bit close);
      int          glen;
      int          dw;
      int          len;
      int          deg;
      int          nbytes;
      int          k;
      int          i;
      logic [31:0] g;
      logic [31:0] m;
      logic [31:0] cw;
      logic [7:0]  b;
      bit          bits_q[$];
      glen = (cfg_len < 2) ? 2 : (cfg_len > 16) ? 16 : cfg_len;
      dw   = cfg_d8 ? 8 : 4;
      len  = dw + glen - 1;
      g    = {16'd0, cfg_poly} & ((32'd1 << glen) - 1);
      deg  = 0;
      for (k = 0; k < glen; k++)
         if (g[k]) deg = k;
      if (with_header)
         repeat (pad) bits_q.push_back(1'($urandom_range(0, 1)));
      repeat (n_cw) begin
         if (g == 0) begin
            cw = $urandom_range(0, (1 << dw) - 1) << (glen - 1);
         end else begin
            m  = $urandom & ((32'd1 << (len - deg)) - 1);
            cw = '0;
            for (k = 0; k < len - deg; k++)
               if (m[k]) cw ^= g << k;
         end
         if ($urandom_range(0, 3) == 0)
            cw ^= 32'd1 << $urandom_range(0, len - 1);
         for (k = len - 1; k >= 0; k--)
            bits_q.push_back(cw[k]);
      end
      repeat (tail) bits_q.push_back(1'($urandom_range(0, 1)));
      while (bits_q.size() % 8 != 0) bits_q.push_back(1'($urandom_range(0, 1)));
      nbytes = bits_q.size() / 8;
      if (with_header)
         send_beat(8'(pad), close && nbytes == 0);
      for (i = 0; i < nbytes; i++) begin
         b = '0;
         for (k = 0; k < 8; k++)
            b = {b[6:0], bits_q[8 * i + k]};
         send_beat(b, close && i == nbytes - 1);
      end
   endtask

   initial begin
      #5ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_stall     = 1'b1;
            repeat (LONG_HOLD) @(negedge clock);
         end
         n = recv_idle ? $urandom_range(0, 5) : 0;
         if (n > 0) begin
            rsp_stall = 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      int phase;
      int n_streams;
      int pad;
      int r;
      int n;
      int i;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      beats_sent    = 0;
      send_idle     = 1'b0;
      recv_idle     = 1'b0;
      long_hold_req = 1'b0;
      repeat (7) @(negedge clock);
      reset = 1'b0;
      write_cfg(RST_GEN_POLY, RST_GEN_LEN, RST_DW_EIGHT);

      // Header beat alone closes an empty stream.
      send_beat(8'd0, 1'b1);
      send_stream(1'b1, 0, 4, 0, 1'b1);
      send_beat(8'd0, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b1);
      // Pad count longer than the whole stream.
      send_beat(8'hFF, 1'b0);
      send_beat(8'hA5, 1'b0);
      send_beat(8'h5A, 1'b1);
      // Trailing partial codeword and partial byte are dropped.
      send_stream(1'b1, 2, 3, 5, 1'b1);
      // Register change in the middle of an open stream.
      send_stream(1'b1, 3, 2, 0, 1'b0);
      wait_idle();
      write_cfg(16'h8005, 5'd16, 1'b1);
      send_stream(1'b0, 0, 1, 3, 1'b1);

      phase = 0;
      while (beats_sent < TARGET_BEATS) begin
         wait_idle();
         case (phase)
            0: write_cfg(16'h0001, 5'd2, 1'b0);
            1: write_cfg(16'hFFFF, 5'd16, 1'b1);
            2: write_cfg(16'h8005, 5'd16, 1'b0);
            3: write_cfg(16'hFFF0, 5'd4, 1'b0);
            4: write_cfg(16'h0013, 5'd8, 1'b1);
            5: write_cfg(16'h0007, 5'd0, 1'b1);
            6: write_cfg(16'hFFFF, 5'd31, 1'b0);
            7: write_cfg(16'h0000, 5'd6, 1'b1);
            default: write_random_cfg();
         endcase
         send_idle = $urandom_range(0, 3) != 0;
         recv_idle = $urandom_range(0, 3) != 0;
         n_streams = $urandom_range(1, 4);
         if (phase == 2) begin
            send_idle     = 1'b0;
            long_hold_req = 1'b1;
            n_streams     = 3;
         end
         repeat (n_streams) begin
            pad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);
            r   = $urandom_range(0, 9);
            if (r == 0) begin
               n = $urandom_range(0, 6);
               send_beat(8'(pad), n == 0);
               for (i = 0; i < n; i++)
                  send_beat(8'($urandom), i == n - 1);
            end else if (r == 1) begin
               send_stream(1'b1, pad, $urandom_range(1, 4), 0, 1'b0);
               wait_idle();
               write_random_cfg();
               send_stream(1'b0, 0, $urandom_range(1, 6), $urandom_range(0, 7), 1'b1);
            end else begin
               send_stream(1'b1, pad, $urandom_range(0, 12),
                           ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0, 1'b1);
            end
         end
         phase++;
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
